>>> rtl/pma_pkg.sv
// ----------------------------------------------------------------------------
// pma_pkg
// Shared types, constants and helpers of the photon moment accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package pma_pkg;

  // Statistics and field widths.
  localparam int NUM_STATS = 6;
  localparam int NUM_VALS  = 3;
  localparam int STAT_W    = 3;
  localparam int WGT_W     = 16;
  localparam int VAL_W     = 24;
  localparam int EVT_W     = 16;
  localparam int ACC_W     = 64;
  localparam int CNT_W     = 32;
  localparam int MUL_W     = 24;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int REM_W     = MUL_W + 2;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Square root unit: one result bit per iteration.
  localparam int SQRT_ITER = MUL_W;
  localparam int ITER_W    = $clog2(SQRT_ITER);

  // Operation codes of an input word.
  localparam logic [1:0] OP_PHOTON = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Statistic indexes.
  localparam logic [STAT_W-1:0] STAT_WEIGHT = 3'd0;
  localparam logic [STAT_W-1:0] STAT_RADIUS = 3'd4;
  localparam logic [STAT_W-1:0] STAT_EVENTS = 3'd5;
  localparam logic [STAT_W-1:0] STAT_LAST   = STAT_W'(NUM_STATS - 1);

  // Command kinds kept in the queue.
  typedef enum logic [1:0] {
    CMD_PHOTON,
    CMD_REPORT,
    CMD_CLEAR
  } cmd_kind_t;

  // One queued command; position magnitudes are taken in the front.
  typedef struct packed {
    cmd_kind_t                            kind;
    logic [WGT_W-1:0]                     weight;
    logic [NUM_VALS-1:0][VAL_W-1:0]       value;
    logic [VAL_W-1:0]                     mag_x;
    logic [VAL_W-1:0]                     mag_y;
    logic [EVT_W-1:0]                     events;
  } cmd_t;

  // Square root unit status toward the back.
  typedef struct packed {
    logic             done;
    logic [MUL_W-1:0] root;
  } sqrt_rsp_t;

  // Back sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_REPORT
  } back_state_t;

  // Where a registered product goes.
  typedef enum logic [2:0] {
    DST_NONE,
    DST_R2_LOAD,
    DST_R2_ADD,
    DST_TMP,
    DST_SUM,
    DST_SQ
  } dest_t;

  typedef struct packed {
    dest_t             dest;
    logic [STAT_W-1:0] idx;
    logic              hi;
  } act_t;

  // Saturating 64-bit add of two unsigned values.
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? '1 : s[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/pma_front.sv
// ----------------------------------------------------------------------------
// pma_front
// Accepts input words, drops those without effect and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module pma_front import pma_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           in_operation,
  input  logic                 in_was_received,
  input  logic [WGT_W-1:0]     in_photon_weight,
  input  logic [VAL_W-1:0]     in_polar_angle,
  input  logic [VAL_W-1:0]     in_flight_time,
  input  logic [VAL_W-1:0]     in_path_length,
  input  logic signed [VAL_W-1:0] in_pos_x,
  input  logic signed [VAL_W-1:0] in_pos_y,
  input  logic [EVT_W-1:0]     in_event_count,
  output logic                 q_empty,
  output cmd_t                 q_head,
  input  logic                 q_pop
);

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              accept;
  logic              keep;
  logic              wr_en;
  cmd_t              cmd;

  // Classify the word: unreceived photons and unused codes are dropped.
  always_comb begin
    keep     = 1'b0;
    cmd.kind = CMD_PHOTON;
    case (in_operation)
      OP_PHOTON: begin
        keep     = in_was_received;
        cmd.kind = CMD_PHOTON;
      end
      OP_REPORT: begin
        keep     = 1'b1;
        cmd.kind = CMD_REPORT;
      end
      OP_CLEAR: begin
        keep     = 1'b1;
        cmd.kind = CMD_CLEAR;
      end
      default: keep = 1'b0;
    endcase
    cmd.weight   = in_photon_weight;
    cmd.value[0] = in_polar_angle;
    cmd.value[1] = in_flight_time;
    cmd.value[2] = in_path_length;
    cmd.mag_x    = in_pos_x[VAL_W-1] ? VAL_W'(-in_pos_x) : in_pos_x;
    cmd.mag_y    = in_pos_y[VAL_W-1] ? VAL_W'(-in_pos_y) : in_pos_y;
    cmd.events   = in_event_count;
  end

  // Queue pointers and fill count.
  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign accept  = push && !full;
  assign wr_en   = accept && keep;
  assign q_head  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pma_sqrt.sv
// ----------------------------------------------------------------------------
// pma_sqrt
// Floor square root of a 48-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pma_sqrt import pma_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] radicand,
  output sqrt_rsp_t         rsp
);

  logic [PROD_W-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [MUL_W-1:0]  root_r, root_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              fits;

  // Bring down two radicand bits and try the next root bit.
  assign rem_sh = {rem_r, rad_r[PROD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    iter_nxt = iter_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      iter_nxt = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[PROD_W-3:0], 2'b00};
      rem_nxt  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_nxt = {root_r[MUL_W-2:0], fits};
      iter_nxt = iter_r + 1'b1;
      if (iter_r == ITER_W'(SQRT_ITER - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

`default_nettype wire

>>> rtl/pma_back.sv
// ----------------------------------------------------------------------------
// pma_back
// Sequencer with one shared multiplier that folds photon moments into the
// saturating accumulators and streams out reports.
// ----------------------------------------------------------------------------
`default_nettype none

module pma_back import pma_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              q_head,
  output logic              q_pop,
  output logic              sqrt_start,
  output logic [PROD_W-1:0] sqrt_radicand,
  input  sqrt_rsp_t         sqrt_rsp,
  output logic              empty,
  input  logic              pop,
  output logic [STAT_W-1:0] out_stat_index,
  output logic [ACC_W-1:0]  out_moment_sum,
  output logic [ACC_W-1:0]  out_moment_square_sum,
  output logic [CNT_W-1:0]  out_received_total,
  output logic              out_last_of_report
);

  // Step numbers of a photon record.
  localparam logic [4:0] ST_AX      = 5'd0;
  localparam logic [4:0] ST_AY      = 5'd1;
  localparam logic [4:0] ST_W       = 5'd2;
  localparam logic [4:0] ST_WW      = 5'd3;
  localparam logic [4:0] ST_V_FIRST = 5'd4;
  localparam logic [4:0] ST_V_LAST  = 5'd15;
  localparam logic [4:0] ST_EE      = 5'd16;
  localparam logic [4:0] ST_WE      = 5'd17;
  localparam logic [4:0] ST_WEE_LO  = 5'd18;
  localparam logic [4:0] ST_WEE_HI  = 5'd19;
  localparam logic [4:0] ST_WR2_LO  = 5'd20;
  localparam logic [4:0] ST_WR2_HI  = 5'd21;
  localparam logic [4:0] ST_WR      = 5'd22;

  // Phases of a theta, time of flight or distance statistic.
  localparam logic [1:0] PH_SQUARE = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SQ_LO  = 2'd2;
  localparam logic [1:0] PH_SQ_HI  = 2'd3;

  back_state_t       state_r, state_nxt;
  logic [4:0]        step_r, step_nxt;
  logic [STAT_W-1:0] k_r, k_nxt;
  cmd_t              item_r;
  act_t              act_r, act_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] r2_r;
  logic [PROD_W-1:0] tmp_r;
  logic [ACC_W-1:0]  sum_r [NUM_STATS];
  logic [ACC_W-1:0]  sq_r  [NUM_STATS];
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_idx_r;
  logic [ACC_W-1:0]  out_sum_r;
  logic [ACC_W-1:0]  out_sq_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_last_r;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [MUL_W-1:0]  w_op;
  logic [1:0]        v_sel;
  logic [MUL_W-1:0]  v_cur;
  logic              stall;
  logic              out_load;
  logic              clr_all;
  logic              cnt_inc;
  logic [STAT_W-1:0] rd_idx;
  logic [ACC_W-1:0]  sum_rd, sq_rd;
  logic [ACC_W-1:0]  addend;
  logic [ACC_W-1:0]  sum_acc, sq_acc;

  assign w_op  = MUL_W'(item_r.weight);
  assign v_sel = 2'(step_r[3:2] - 2'd1);
  assign v_cur = item_r.value[v_sel];
  assign stall = (step_r == ST_WR) && !sqrt_rsp.done;

  // Operand selection and product routing of the current step.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    act_nxt = '{dest: DST_NONE, idx: '0, hi: 1'b0};
    if (state_r == BK_CALC) begin
      if (step_r inside {[ST_V_FIRST:ST_V_LAST]}) begin
        act_nxt.idx = STAT_W'(step_r[3:2]);
        case (step_r[1:0])
          PH_SQUARE: begin
            mul_a        = v_cur;
            mul_b        = v_cur;
            act_nxt.dest = DST_TMP;
          end
          PH_FIRST: begin
            mul_a        = w_op;
            mul_b        = v_cur;
            act_nxt.dest = DST_SUM;
          end
          PH_SQ_LO: begin
            mul_a        = w_op;
            mul_b        = tmp_r[MUL_W-1:0];
            act_nxt.dest = DST_SQ;
          end
          PH_SQ_HI: begin
            mul_a        = w_op;
            mul_b        = tmp_r[PROD_W-1:MUL_W];
            act_nxt.dest = DST_SQ;
            act_nxt.hi   = 1'b1;
          end
          default: act_nxt.dest = DST_NONE;
        endcase
      end else begin
        case (step_r)
          ST_AX: begin
            mul_a        = item_r.mag_x;
            mul_b        = item_r.mag_x;
            act_nxt.dest = DST_R2_LOAD;
          end
          ST_AY: begin
            mul_a        = item_r.mag_y;
            mul_b        = item_r.mag_y;
            act_nxt.dest = DST_R2_ADD;
          end
          ST_W: begin
            mul_a        = w_op;
            mul_b        = MUL_W'(1);
            act_nxt.dest = DST_SUM;
            act_nxt.idx  = STAT_WEIGHT;
          end
          ST_WW: begin
            mul_a        = w_op;
            mul_b        = w_op;
            act_nxt.dest = DST_SQ;
            act_nxt.idx  = STAT_WEIGHT;
          end
          ST_EE: begin
            mul_a        = MUL_W'(item_r.events);
            mul_b        = MUL_W'(item_r.events);
            act_nxt.dest = DST_TMP;
          end
          ST_WE: begin
            mul_a        = w_op;
            mul_b        = MUL_W'(item_r.events);
            act_nxt.dest = DST_SUM;
            act_nxt.idx  = STAT_EVENTS;
          end
          ST_WEE_LO: begin
            mul_a        = w_op;
            mul_b        = tmp_r[MUL_W-1:0];
            act_nxt.dest = DST_SQ;
            act_nxt.idx  = STAT_EVENTS;
          end
          ST_WEE_HI: begin
            mul_a        = w_op;
            mul_b        = tmp_r[PROD_W-1:MUL_W];
            act_nxt.dest = DST_SQ;
            act_nxt.idx  = STAT_EVENTS;
            act_nxt.hi   = 1'b1;
          end
          ST_WR2_LO: begin
            mul_a        = w_op;
            mul_b        = r2_r[MUL_W-1:0];
            act_nxt.dest = DST_SQ;
            act_nxt.idx  = STAT_RADIUS;
          end
          ST_WR2_HI: begin
            mul_a        = w_op;
            mul_b        = r2_r[PROD_W-1:MUL_W];
            act_nxt.dest = DST_SQ;
            act_nxt.idx  = STAT_RADIUS;
            act_nxt.hi   = 1'b1;
          end
          ST_WR: begin
            if (sqrt_rsp.done) begin
              mul_a        = w_op;
              mul_b        = sqrt_rsp.root;
              act_nxt.dest = DST_SUM;
              act_nxt.idx  = STAT_RADIUS;
            end
          end
          default: act_nxt.dest = DST_NONE;
        endcase
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          case (q_head.kind)
            CMD_PHOTON: state_nxt = BK_CALC;
            CMD_REPORT: state_nxt = BK_REPORT;
            default:    state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_CALC: begin
        if (step_r == ST_WR && !stall) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_REPORT: begin
        if (out_load && k_r == STAT_LAST) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop      = (state_r == BK_IDLE) && !q_empty;
    cnt_inc    = q_pop && (q_head.kind == CMD_PHOTON);
    clr_all    = q_pop && (q_head.kind == CMD_CLEAR);
    sqrt_start = (state_r == BK_CALC) && (step_r == ST_WW);
    out_load   = (state_r == BK_REPORT) && (!out_valid_r || pop);
    step_nxt   = step_r;
    k_nxt      = k_r;
    case (state_r)
      BK_IDLE: begin
        step_nxt = '0;
        k_nxt    = '0;
      end
      BK_CALC: begin
        if (!stall) begin
          step_nxt = step_r + 1'b1;
        end
      end
      BK_REPORT: begin
        if (out_load) begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: step_nxt = '0;
    endcase
  end

  assign sqrt_radicand = r2_r;

  // Accumulator read and saturating add.
  assign rd_idx  = (state_r == BK_REPORT) ? k_r : act_r.idx;
  assign sum_rd  = sum_r[rd_idx];
  assign sq_rd   = sq_r[rd_idx];
  assign addend  = act_r.hi ? {prod_r[ACC_W-MUL_W-1:0], {MUL_W{1'b0}}}
                            : ACC_W'(prod_r);
  assign sum_acc = sat_add(sum_rd, addend);
  assign sq_acc  = sat_add(sq_rd, addend);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= '0;
      k_r         <= '0;
      act_r       <= '{dest: DST_NONE, idx: '0, hi: 1'b0};
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      k_r     <= k_nxt;
      act_r   <= act_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Accumulators and received count; a clear wins over a pending add.
  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      cnt_r <= '0;
      for (int i = 0; i < NUM_STATS; i++) begin
        sum_r[i] <= '0;
        sq_r[i]  <= '0;
      end
    end else begin
      if (cnt_inc && cnt_r != '1) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (act_r.dest == DST_SUM) begin
        sum_r[act_r.idx] <= sum_acc;
      end
      if (act_r.dest == DST_SQ) begin
        sq_r[act_r.idx] <= sq_acc;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (q_pop) begin
      item_r <= q_head;
    end
    case (act_r.dest)
      DST_R2_LOAD: r2_r  <= prod_r;
      DST_R2_ADD:  r2_r  <= r2_r + prod_r;
      DST_TMP:     tmp_r <= prod_r;
      default:     tmp_r <= tmp_r;
    endcase
    if (out_load) begin
      out_idx_r  <= k_r;
      out_sum_r  <= sum_rd;
      out_sq_r   <= sq_rd;
      out_cnt_r  <= cnt_r;
      out_last_r <= (k_r == STAT_LAST);
    end
  end

  assign empty                 = !out_valid_r;
  assign out_stat_index        = out_idx_r;
  assign out_moment_sum        = out_sum_r;
  assign out_moment_square_sum = out_sq_r;
  assign out_received_total    = out_cnt_r;
  assign out_last_of_report    = out_last_r;

`ifndef NO_ASSERTIONS
  // No product may still be on its way into an accumulator during a report.
  a_report_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_REPORT |-> act_r.dest == DST_NONE)
    else $error("accumulator update pending during report");

  // The sixth result of a report returns the sequencer to idle.
  a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && k_r == STAT_LAST |=> state_r == BK_IDLE)
    else $error("report did not end after the last statistic");

  // The radius sum is only taken once the square root has finished.
  a_root_ready: assert property (@(posedge clk) disable iff (!rst_n)
    act_nxt.dest == DST_SUM && act_nxt.idx == STAT_RADIUS |-> sqrt_rsp.done)
    else $error("radius used before the square root finished");

  // The received count only falls on a clear.
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(clr_all) |-> cnt_r >= $past(cnt_r))
    else $error("received count decreased without a clear");
`endif

endmodule

`default_nettype wire

>>> rtl/photon_moment_accumulator.sv
// ----------------------------------------------------------------------------
// photon_moment_accumulator
// Weighted sum and sum of squares of six photon statistics, fixed point.
// ----------------------------------------------------------------------------
// Photon records, report and clear requests enter through a two-word queue.
// Unreceived photons and unused codes are taken at the input and go no further.
// A received photon occupies the back end for 23 steps of the shared 24x24
// multiplier, with the radius step waiting on the square root unit, which
// delivers one root bit per cycle. A clear is carried out as it leaves the
// queue; a report hands out its results in turn, loading each once the
// result side has taken the one before. Sums saturate at all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module photon_moment_accumulator import pma_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              in_operation,
  input  logic                    in_was_received,
  input  logic [WGT_W-1:0]        in_photon_weight,
  input  logic [VAL_W-1:0]        in_polar_angle,
  input  logic [VAL_W-1:0]        in_flight_time,
  input  logic [VAL_W-1:0]        in_path_length,
  input  logic signed [VAL_W-1:0] in_pos_x,
  input  logic signed [VAL_W-1:0] in_pos_y,
  input  logic [EVT_W-1:0]        in_event_count,
  output logic                    empty,
  input  logic                    pop,
  output logic [STAT_W-1:0]       out_stat_index,
  output logic [ACC_W-1:0]        out_moment_sum,
  output logic [ACC_W-1:0]        out_moment_square_sum,
  output logic [CNT_W-1:0]        out_received_total,
  output logic                    out_last_of_report
);

  logic              q_empty;
  cmd_t              q_head;
  logic              q_pop;
  logic              sqrt_start;
  logic [PROD_W-1:0] sqrt_radicand;
  sqrt_rsp_t         sqrt_rsp;

  // Input side: classify and queue commands.
  pma_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_operation     (in_operation),
    .in_was_received  (in_was_received),
    .in_photon_weight (in_photon_weight),
    .in_polar_angle   (in_polar_angle),
    .in_flight_time   (in_flight_time),
    .in_path_length   (in_path_length),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_event_count   (in_event_count),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop)
  );

  // Radius square root.
  pma_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_radicand),
    .rsp      (sqrt_rsp)
  );

  // Accumulation and report sequencing.
  pma_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_head                (q_head),
    .q_pop                 (q_pop),
    .sqrt_start            (sqrt_start),
    .sqrt_radicand         (sqrt_radicand),
    .sqrt_rsp              (sqrt_rsp),
    .empty                 (empty),
    .pop                   (pop),
    .out_stat_index        (out_stat_index),
    .out_moment_sum        (out_moment_sum),
    .out_moment_square_sum (out_moment_square_sum),
    .out_received_total    (out_received_total),
    .out_last_of_report    (out_last_of_report)
  );

endmodule

`default_nettype wire
